[sv/acbc_pkg.sv]
// acbc_pkg: shared types, register indexes and AES byte functions for the CBC cipher.
// Used by acbc_ctrl, acbc_ksched, acbc_dp, aes_cbc_cipher and tb; depends on nothing.
package acbc_pkg;

	localparam logic [2:0] REG_KEY0     = 3'd0;
	localparam logic [2:0] REG_KEY1     = 3'd1;
	localparam logic [2:0] REG_KEY2     = 3'd2;
	localparam logic [2:0] REG_KEY3     = 3'd3;
	localparam logic [2:0] REG_KEY_SIZE = 3'd4;
	localparam logic [2:0] REG_DIR      = 3'd5;
	localparam logic [2:0] REG_IV_HIGH  = 3'd6;
	localparam logic [2:0] REG_IV_LOW   = 3'd7;

	localparam logic [1:0] KS_128 = 2'd0;
	localparam logic [1:0] KS_192 = 2'd1;

	localparam logic DIR_DEC = 1'b1;

	// controller to datapath and key schedule
	typedef struct packed {
		logic       load;
		logic       round;
		logic       last;
		logic       out_write;
		logic [3:0] rk_addr;
		logic       preload;
		logic       step;
		logic [5:0] wr_idx;
		logic       mod_zero;
		logic       mod_four;
		logic [3:0] rcon_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_status_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] rcon(input logic [3:0] idx);
		logic [7:0] r;
		unique case (idx)
			4'd1:    r = 8'h01;
			4'd2:    r = 8'h02;
			4'd3:    r = 8'h04;
			4'd4:    r = 8'h08;
			4'd5:    r = 8'h10;
			4'd6:    r = 8'h20;
			4'd7:    r = 8'h40;
			4'd8:    r = 8'h80;
			4'd9:    r = 8'h1b;
			4'd10:   r = 8'h36;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [7:0] xtime(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// one encryption round: SubBytes, ShiftRows, MixColumns unless final, AddRoundKey
	function automatic logic [127:0] enc_round(input logic [127:0] st, input logic [127:0] rk,
			input logic no_mix);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		for (int k = 0; k < 16; k++) s[k] = SBOX[st[127-8*k -: 8]];
		for (int c = 0; c < 4; c++)
			for (int w = 0; w < 4; w++) t[4*c+w] = s[4*((c+w)&3)+w];
		if (!no_mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				t[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
				t[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
				t[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
				t[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
			end
		end
		for (int k = 0; k < 16; k++) r[127-8*k -: 8] = t[k];
		return r ^ rk;
	endfunction

	function automatic logic [7:0] mul9(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ a;
	endfunction

	function automatic logic [7:0] mul11(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(a) ^ a;
	endfunction

	function automatic logic [7:0] mul13(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ a;
	endfunction

	function automatic logic [7:0] mul14(input logic [7:0] a);
		return xtime(xtime(xtime(a))) ^ xtime(xtime(a)) ^ xtime(a);
	endfunction

	// one decryption round: InvShiftRows, InvSubBytes, AddRoundKey, InvMixColumns unless final
	function automatic logic [127:0] dec_round(input logic [127:0] st, input logic [127:0] rk,
			input logic no_mix);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		for (int k = 0; k < 16; k++) s[k] = st[127-8*k -: 8];
		for (int c = 0; c < 4; c++)
			for (int w = 0; w < 4; w++)
				t[4*c+w] = INV_SBOX[s[4*((c-w+4)&3)+w]] ^ rk[127-8*(4*c+w) -: 8];
		if (!no_mix) begin
			for (int c = 0; c < 4; c++) begin
				a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
				t[4*c]   = mul14(a0) ^ mul11(a1) ^ mul13(a2) ^ mul9(a3);
				t[4*c+1] = mul9(a0) ^ mul14(a1) ^ mul11(a2) ^ mul13(a3);
				t[4*c+2] = mul13(a0) ^ mul9(a1) ^ mul14(a2) ^ mul11(a3);
				t[4*c+3] = mul11(a0) ^ mul13(a1) ^ mul9(a2) ^ mul14(a3);
			end
		end
		for (int k = 0; k < 16; k++) r[127-8*k -: 8] = t[k];
		return r;
	endfunction

endpackage

[sv/acbc_ctrl.sv]
// acbc_ctrl: state machine sequencing key expansion and the cipher rounds.
// Depends on acbc_pkg; drives acbc_ksched and acbc_dp through ctrl_cmd_t.
module acbc_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic                   key_wr,
	input  logic [1:0]             key_size,
	input  logic                   direction,
	input  acbc_pkg::dp_status_t   status,
	output acbc_pkg::ctrl_cmd_t    cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PRE  = 2'd1;
	localparam logic [1:0] ST_EXP  = 2'd2;
	localparam logic [1:0] ST_RUN  = 2'd3;

	logic [1:0] state_q;
	logic       dirty_q;
	logic [5:0] idx_q;
	logic [2:0] mod_q;
	logic [3:0] rcon_q;
	logic [3:0] rnd_q;

	logic [5:0] nk;
	logic [5:0] last_idx;
	logic [3:0] nr;
	logic       dec;
	logic       accept;
	logic       last_rnd;

	always_comb begin
		unique case (key_size)
			acbc_pkg::KS_128: begin nk = 6'd4; last_idx = 6'd43; nr = 4'd10; end
			acbc_pkg::KS_192: begin nk = 6'd6; last_idx = 6'd51; nr = 4'd12; end
			default:          begin nk = 6'd8; last_idx = 6'd59; nr = 4'd14; end
		endcase
	end

	assign dec      = (direction == acbc_pkg::DIR_DEC);
	assign in_stall = !((state_q == ST_IDLE) && !dirty_q);
	assign accept   = in_valid && !in_stall;
	assign last_rnd = dec ? (rnd_q == 4'd1) : (rnd_q == nr);

	always_comb begin
		cmd           = '0;
		cmd.wr_idx    = idx_q;
		cmd.mod_zero  = (mod_q == 3'd0);
		cmd.mod_four  = (mod_q == 3'd4);
		cmd.rcon_idx  = rcon_q;
		cmd.last      = last_rnd;
		cmd.rk_addr   = dec ? nr : 4'd0;
		unique case (state_q)
			ST_IDLE: cmd.load = accept;
			ST_PRE:  cmd.preload = 1'b1;
			ST_EXP:  cmd.step = 1'b1;
			ST_RUN: begin
				cmd.round     = 1'b1;
				cmd.rk_addr   = dec ? rnd_q - 4'd1 : rnd_q;
				cmd.out_write = last_rnd && status.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b1;
			idx_q   <= '0;
			mod_q   <= '0;
			rcon_q  <= '0;
			rnd_q   <= '0;
		end else begin
			// a key write during a rebuild leaves the schedule dirty again
			if (key_wr)
				dirty_q <= 1'b1;
			else if ((state_q == ST_IDLE) && dirty_q)
				dirty_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (dirty_q) begin
						state_q <= ST_PRE;
					end else if (accept) begin
						rnd_q   <= dec ? nr : 4'd1;
						state_q <= ST_RUN;
					end
				end
				ST_PRE: begin
					idx_q   <= nk;
					mod_q   <= 3'd0;
					rcon_q  <= 4'd1;
					state_q <= ST_EXP;
				end
				ST_EXP: begin
					idx_q <= idx_q + 6'd1;
					if ({3'd0, mod_q} == nk - 6'd1) begin
						mod_q  <= 3'd0;
						rcon_q <= rcon_q + 4'd1;
					end else begin
						mod_q <= mod_q + 3'd1;
					end
					if (idx_q >= last_idx) state_q <= ST_IDLE;
				end
				ST_RUN: begin
					if (!last_rnd) begin
						rnd_q <= dec ? rnd_q - 4'd1 : rnd_q + 4'd1;
					end else if (status.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[sv/acbc_ksched.sv]
// acbc_ksched: key expansion one schedule word a cycle, and the round key store.
// Depends on acbc_pkg; stepped by acbc_ctrl, read by acbc_dp.
module acbc_ksched (
	input  logic                 clk,
	input  logic [255:0]         key,
	input  logic [1:0]           key_size,
	input  acbc_pkg::ctrl_cmd_t  cmd,
	output logic [127:0]         rk
);

	logic [31:0]  win_q [8];
	logic [127:0] rk_q [15];

	logic [31:0] kw [8];
	logic [31:0] pre [8];
	logic [31:0] back;
	logic [31:0] t;
	logic [31:0] new_w;
	logic        nk8;

	assign nk8 = (key_size != acbc_pkg::KS_128) && (key_size != acbc_pkg::KS_192);

	always_comb begin
		for (int j = 0; j < 8; j++) kw[j] = key[255-32*j -: 32];
		// window holds w[i-1] at tap 0 back to w[i-nk]
		for (int j = 0; j < 8; j++) begin
			unique case (key_size)
				acbc_pkg::KS_128: pre[j] = (j < 4) ? kw[(3-j)&7] : 32'd0;
				acbc_pkg::KS_192: pre[j] = (j < 6) ? kw[(5-j)&7] : 32'd0;
				default:          pre[j] = kw[7-j];
			endcase
		end
		unique case (key_size)
			acbc_pkg::KS_128: back = win_q[3];
			acbc_pkg::KS_192: back = win_q[5];
			default:          back = win_q[7];
		endcase
		if (cmd.mod_zero)
			t = acbc_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]}) ^
				{acbc_pkg::rcon(cmd.rcon_idx), 24'd0};
		else if (nk8 && cmd.mod_four)
			t = acbc_pkg::sub_word(win_q[0]);
		else
			t = win_q[0];
		new_w = back ^ t;
	end

	always_ff @(posedge clk) begin
		if (cmd.preload) begin
			for (int j = 0; j < 8; j++) win_q[j] <= pre[j];
			rk_q[0] <= key[255:128];
			rk_q[1] <= key[127:0];
		end else if (cmd.step) begin
			win_q[0] <= new_w;
			for (int j = 1; j < 8; j++) win_q[j] <= win_q[j-1];
			unique case (cmd.wr_idx[1:0])
				2'd0: rk_q[cmd.wr_idx[5:2]][127:96] <= new_w;
				2'd1: rk_q[cmd.wr_idx[5:2]][95:64]  <= new_w;
				2'd2: rk_q[cmd.wr_idx[5:2]][63:32]  <= new_w;
				2'd3: rk_q[cmd.wr_idx[5:2]][31:0]   <= new_w;
				default: ;
			endcase
		end
	end

	assign rk = rk_q[cmd.rk_addr];

endmodule

[sv/acbc_dp.sv]
// acbc_dp: cipher state, chain value and output word register.
// Depends on acbc_pkg; commanded by acbc_ctrl, round keys from acbc_ksched.
module acbc_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  acbc_pkg::ctrl_cmd_t   cmd,
	input  logic [127:0]          rk,
	input  logic                  direction,
	input  logic [127:0]          iv,
	input  logic                  iv_wr,
	input  logic [127:0]          iv_wdata,
	input  logic [63:0]           in_high,
	input  logic [63:0]           in_low,
	input  logic                  in_last,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [63:0]           out_high,
	output logic [63:0]           out_low,
	output logic                  out_last,
	output acbc_pkg::dp_status_t  status
);

	logic [127:0] st_q;
	logic [127:0] blk_q;
	logic         last_q;
	logic [127:0] chain_q;
	logic [127:0] out_q;
	logic         out_last_q;
	logic         out_valid_q;

	logic         dec;
	logic [127:0] in_blk;
	logic [127:0] rnd_out;

	assign dec    = (direction == acbc_pkg::DIR_DEC);
	assign in_blk = {in_high, in_low};
	assign rnd_out = dec ? acbc_pkg::dec_round(st_q, rk, cmd.last)
	                     : acbc_pkg::enc_round(st_q, rk, cmd.last);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			st_q   <= dec ? (in_blk ^ rk) : (in_blk ^ chain_q ^ rk);
			blk_q  <= in_blk;
			last_q <= in_last;
		end else if (cmd.round && !cmd.last) begin
			st_q <= rnd_out;
		end
		if (cmd.out_write) begin
			out_q      <= dec ? (rnd_out ^ chain_q) : rnd_out;
			out_last_q <= last_q;
		end
	end

	// chain resets to the zero IV
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chain_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (iv_wr)
				chain_q <= iv_wdata;
			else if (cmd.out_write)
				chain_q <= last_q ? iv : (dec ? blk_q : rnd_out);
			if (cmd.out_write)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign status.out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_high  = out_q[127:64];
	assign out_low   = out_q[63:0];
	assign out_last  = out_last_q;

endmodule

[sv/aes_cbc_cipher.sv]
// AES-128/192/256 block cipher in CBC mode, one round per clock; the last round
// waits while the output register still holds an untaken result. A block word
// is taken when the core is idle; it then runs Nr rounds (10, 12 or 14 by key
// size) and the result word lands in the output register on the last round.
// With its single round unit the core takes the next word only once the rounds
// of the last one are done. The result can wait in the output register while
// the next block runs. After reset and after any write of a key word or the key
// size, the schedule is rebuilt one 32-bit word a cycle, while in_stall stays high.
// Writing either IV half reloads the chain; a word with in_last set reloads the
// chain from the IV registers once its result is formed.
// Depends on acbc_pkg, acbc_ctrl, acbc_ksched, acbc_dp.
module aes_cbc_cipher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] in_high,
	input  logic [63:0] in_low,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] out_high,
	output logic [63:0] out_low,
	output logic        out_last
);

	logic [63:0] key0_q, key1_q, key2_q, key3_q;
	logic [1:0]  key_size_q;
	logic        dir_q;
	logic [63:0] iv_high_q, iv_low_q;

	logic                 cfg_wr;
	logic                 key_wr;
	logic                 iv_wr;
	logic [127:0]         iv_wdata;
	logic [127:0]         rk;
	acbc_pkg::ctrl_cmd_t  cmd;
	acbc_pkg::dp_status_t status;

	// register file is always writable
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign key_wr    = cfg_wr && ((cfg_index == acbc_pkg::REG_KEY0) ||
		(cfg_index == acbc_pkg::REG_KEY1) || (cfg_index == acbc_pkg::REG_KEY2) ||
		(cfg_index == acbc_pkg::REG_KEY3) || (cfg_index == acbc_pkg::REG_KEY_SIZE));
	assign iv_wr     = cfg_wr && ((cfg_index == acbc_pkg::REG_IV_HIGH) ||
		(cfg_index == acbc_pkg::REG_IV_LOW));
	// chain takes the IV as it stands after this write
	assign iv_wdata  = {(cfg_index == acbc_pkg::REG_IV_HIGH) ? cfg_data : iv_high_q,
	                    (cfg_index == acbc_pkg::REG_IV_LOW)  ? cfg_data : iv_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key0_q     <= '0;
			key1_q     <= '0;
			key2_q     <= '0;
			key3_q     <= '0;
			key_size_q <= '0;
			dir_q      <= 1'b0;
			iv_high_q  <= '0;
			iv_low_q   <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				acbc_pkg::REG_KEY0:     key0_q     <= cfg_data;
				acbc_pkg::REG_KEY1:     key1_q     <= cfg_data;
				acbc_pkg::REG_KEY2:     key2_q     <= cfg_data;
				acbc_pkg::REG_KEY3:     key3_q     <= cfg_data;
				acbc_pkg::REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
				acbc_pkg::REG_DIR:      dir_q      <= cfg_data[0];
				acbc_pkg::REG_IV_HIGH:  iv_high_q  <= cfg_data;
				acbc_pkg::REG_IV_LOW:   iv_low_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	acbc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.key_wr    (key_wr),
		.key_size  (key_size_q),
		.direction (dir_q),
		.status    (status),
		.cmd       (cmd)
	);

	acbc_ksched u_ksched (
		.clk      (clk),
		.key      ({key0_q, key1_q, key2_q, key3_q}),
		.key_size (key_size_q),
		.cmd      (cmd),
		.rk       (rk)
	);

	acbc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rk        (rk),
		.direction (dir_q),
		.iv        ({iv_high_q, iv_low_q}),
		.iv_wr     (iv_wr),
		.iv_wdata  (iv_wdata),
		.in_high   (in_high),
		.in_low    (in_low),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_high  (out_high),
		.out_low   (out_low),
		.out_last  (out_last),
		.status    (status)
	);

endmodule

[sim/tb.sv]
// tb: self-checking bench for aes_cbc_cipher, AES-128/192/256 in CBC mode.
// Depends on acbc_pkg (register indexes, S-box table) and the aes_cbc_cipher RTL.
module tb;

	localparam int RUN_WORDS  = 1800;
	localparam int CYCLE_CAP  = 600000;
	localparam int DRAIN_WAIT = 40;   // > one AES-256 block plus margin

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] in_high = '0;
	logic [63:0] in_low = '0;
	logic        in_last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] out_high;
	logic [63:0] out_low;
	logic        out_last;

	aes_cbc_cipher i_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// AES/CBC predictor
	// ---------------------------------------------------------------
	typedef struct packed {
		logic [63:0] hi;
		logic [63:0] lo;
		logic        last;
	} blk_word_t;

	logic [7:0]  fwd_sb [256];
	logic [7:0]  inv_sb [256];
	logic [63:0] key_r [4];
	logic [1:0]  ksz_r;
	logic        dir_r;
	logic [63:0] iv_hi_r, iv_lo_r;
	logic [127:0] chain_r;
	logic [31:0] sched [60];

	blk_word_t cbc_expect_q[$];
	int        n_fail = 0;

	function automatic int round_count();
		return (ksz_r == acbc_pkg::KS_128) ? 10 : ((ksz_r == acbc_pkg::KS_192) ? 12 : 14);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] p;
		p = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[0])
				p ^= a;
			a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
			b = b >> 1;
		end
		return p;
	endfunction

	function automatic logic [7:0] rcon_of(input int n);
		logic [7:0] r;
		r = 8'h01;
		for (int i = 1; i < n; i++)
			r = {r[6:0], 1'b0} ^ (r[7] ? 8'h1b : 8'h00);
		return r;
	endfunction

	function automatic void build_schedule();
		int nr, nk, total;
		logic [31:0] t;
		nr = round_count();
		nk = nr - 6;
		total = 4 * (nr + 1);
		for (int i = 0; i < 8; i++)
			sched[i] = i[0] ? key_r[i/2][31:0] : key_r[i/2][63:32];
		for (int i = nk; i < total; i++) begin
			t = sched[i-1];
			if (i % nk == 0) begin
				t = {t[23:0], t[31:24]};
				t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
				t[31:24] ^= rcon_of(i / nk);
			end else if (nk > 6 && i % nk == 4) begin
				t = {fwd_sb[t[31:24]], fwd_sb[t[23:16]], fwd_sb[t[15:8]], fwd_sb[t[7:0]]};
			end
			sched[i] = sched[i-nk] ^ t;
		end
	endfunction

	function automatic logic [127:0] aes_block(input logic [127:0] b, input logic dec);
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [7:0] a0, a1, a2, a3;
		logic [127:0] r;
		int nr;
		nr = round_count();
		for (int k = 0; k < 16; k++)
			s[k] = b[127-8*k -: 8];
		if (!dec) begin
			for (int k = 0; k < 16; k++)
				s[k] ^= sched[k/4][31-8*(k%4) -: 8];
			for (int rd = 1; rd <= nr; rd++) begin
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						t[4*c+w] = fwd_sb[s[4*((c+w)&3)+w]];
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					if (rd != nr) begin
						t[4*c]   = gf_mul(a0,8'd2) ^ gf_mul(a1,8'd3) ^ a2 ^ a3;
						t[4*c+1] = a0 ^ gf_mul(a1,8'd2) ^ gf_mul(a2,8'd3) ^ a3;
						t[4*c+2] = a0 ^ a1 ^ gf_mul(a2,8'd2) ^ gf_mul(a3,8'd3);
						t[4*c+3] = gf_mul(a0,8'd3) ^ a1 ^ a2 ^ gf_mul(a3,8'd2);
					end
				end
				for (int k = 0; k < 16; k++)
					s[k] = t[k] ^ sched[4*rd + k/4][31-8*(k%4) -: 8];
			end
		end else begin
			for (int k = 0; k < 16; k++)
				s[k] ^= sched[4*nr + k/4][31-8*(k%4) -: 8];
			for (int rd = nr; rd > 0; rd--) begin
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++)
						t[4*((c+w)&3)+w] = inv_sb[s[4*c+w]];
				for (int k = 0; k < 16; k++)
					t[k] ^= sched[4*(rd-1) + k/4][31-8*(k%4) -: 8];
				for (int c = 0; c < 4; c++) begin
					a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
					if (rd != 1) begin
						t[4*c]   = gf_mul(a0,8'd14) ^ gf_mul(a1,8'd11) ^
							gf_mul(a2,8'd13) ^ gf_mul(a3,8'd9);
						t[4*c+1] = gf_mul(a0,8'd9) ^ gf_mul(a1,8'd14) ^
							gf_mul(a2,8'd11) ^ gf_mul(a3,8'd13);
						t[4*c+2] = gf_mul(a0,8'd13) ^ gf_mul(a1,8'd9) ^
							gf_mul(a2,8'd14) ^ gf_mul(a3,8'd11);
						t[4*c+3] = gf_mul(a0,8'd11) ^ gf_mul(a1,8'd13) ^
							gf_mul(a2,8'd9) ^ gf_mul(a3,8'd14);
					end
				end
				for (int k = 0; k < 16; k++)
					s[k] = t[k];
			end
		end
		for (int k = 0; k < 16; k++)
			r[127-8*k -: 8] = s[k];
		return r;
	endfunction

	// chain update for one accepted word; returns the expected result word
	function automatic blk_word_t cbc_predict(input blk_word_t w);
		blk_word_t   res;
		logic [127:0] v;
		if (dir_r != acbc_pkg::DIR_DEC) begin
			v = aes_block({w.hi, w.lo} ^ chain_r, 1'b0);
			chain_r = v;
		end else begin
			v = aes_block({w.hi, w.lo}, 1'b1) ^ chain_r;
			chain_r = {w.hi, w.lo};
		end
		if (w.last)
			chain_r = {iv_hi_r, iv_lo_r};
		res.hi = v[127:64];
		res.lo = v[63:0];
		res.last = w.last;
		return res;
	endfunction

	// ---------------------------------------------------------------
	// idling / pressure controls
	// ---------------------------------------------------------------
	bit tx_gaps = 1'b1;   // sender inserts random gaps
	bit rx_gaps = 1'b1;   // receiver stalls at random
	bit rx_hold = 1'b0;   // long receiver hold-off
	int cycle_cnt = 0;

	always @(negedge clk)
		out_stall <= rx_hold || (rx_gaps && $urandom_range(99) < 27);

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > CYCLE_CAP) begin
			$display("aes_cbc_cipher test failed");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		blk_word_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (cbc_expect_q.size() == 0) begin
				$error("unexpected result word %h_%h", out_high, out_low);
				n_fail++;
			end else begin
				e = cbc_expect_q.pop_front();
				if (out_high !== e.hi) begin
					$error("out_high exp %h got %h", e.hi, out_high);
					n_fail++;
				end
				if (out_low !== e.lo) begin
					$error("out_low exp %h got %h", e.lo, out_low);
					n_fail++;
				end
				if (out_last !== e.last) begin
					$error("out_last exp %b got %b", e.last, out_last);
					n_fail++;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// drivers
	// ---------------------------------------------------------------
	task automatic wait_idle();
		while (cbc_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		@(negedge clk);
	endtask

	// caller guarantees the core is idle
	task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			acbc_pkg::REG_KEY0:     key_r[0] = val;
			acbc_pkg::REG_KEY1:     key_r[1] = val;
			acbc_pkg::REG_KEY2:     key_r[2] = val;
			acbc_pkg::REG_KEY3:     key_r[3] = val;
			acbc_pkg::REG_KEY_SIZE: ksz_r = val[1:0];
			acbc_pkg::REG_DIR:      dir_r = val[0];
			acbc_pkg::REG_IV_HIGH: begin
				iv_hi_r = val;
				chain_r = {iv_hi_r, iv_lo_r};
			end
			acbc_pkg::REG_IV_LOW: begin
				iv_lo_r = val;
				chain_r = {iv_hi_r, iv_lo_r};
			end
		endcase
		build_schedule();
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// ends on a falling edge with in_valid still high; the next call decides
	task automatic send_word(input logic [63:0] hi, input logic [63:0] lo, input logic last);
		blk_word_t w;
		while (tx_gaps && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_high  <= hi;
		in_low   <= lo;
		in_last  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		w.hi = hi;
		w.lo = lo;
		w.last = last;
		cbc_expect_q.push_back(cbc_predict(w));
		@(negedge clk);
	endtask

	task automatic park_input();
		in_valid <= 1'b0;
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// ---------------------------------------------------------------
	// directed vectors (FIPS-197 appendix C plus extremes)
	// ---------------------------------------------------------------
	typedef struct {
		bit          seq_key;  // 0: all-zero key, 1: 00 01 02 .. 1f
		logic [1:0]  ksz;
		logic        dir;
		logic [63:0] hi, lo;
		logic        last;
		bit          known;
		logic [127:0] res;
	} vec_row_t;

	localparam logic [63:0] PT_HI = 64'h0011223344556677, PT_LO = 64'h8899aabbccddeeff;
	localparam logic [63:0] ONES = '1;

	vec_row_t vecs[] = '{
		'{0, 2'd0, 1'b0, 64'h0, 64'h0, 1'b1, 1, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
		'{1, 2'd0, 1'b0, PT_HI, PT_LO, 1'b1, 1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
		'{1, 2'd1, 1'b0, PT_HI, PT_LO, 1'b1, 1, 128'hdda97ca4864cdfe06eaf70a0ec0d7191},
		'{1, 2'd2, 1'b0, PT_HI, PT_LO, 1'b1, 1, 128'h8ea2b7ca516745bfeafc49904b496089},
		// unused key-size code runs as AES-256
		'{1, 2'd3, 1'b0, PT_HI, PT_LO, 1'b1, 1, 128'h8ea2b7ca516745bfeafc49904b496089},
		'{1, 2'd0, 1'b1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1'b1, 1, {PT_HI, PT_LO}},
		'{1, 2'd1, 1'b1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1'b1, 1, {PT_HI, PT_LO}},
		'{1, 2'd2, 1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1, 1, {PT_HI, PT_LO}},
		'{1, 2'd3, 1'b1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1'b1, 1, {PT_HI, PT_LO}},
		// chained messages, extremes: predictor only
		'{1, 2'd0, 1'b0, ONES, ONES, 1'b0, 0, '0},
		'{1, 2'd0, 1'b0, 64'h0, 64'h0, 1'b0, 0, '0},
		'{1, 2'd0, 1'b0, ONES, 64'h0, 1'b1, 0, '0},
		'{1, 2'd2, 1'b1, ONES, ONES, 1'b0, 0, '0},
		'{1, 2'd2, 1'b1, 64'h0, ONES, 1'b0, 0, '0},
		'{1, 2'd2, 1'b1, 64'h0, 64'h0, 1'b1, 0, '0},
		'{1, 2'd1, 1'b0, 64'h8000000000000001, ONES, 1'b0, 0, '0},
		'{1, 2'd1, 1'b0, PT_HI, PT_LO, 1'b1, 0, '0}
	};

	task automatic run_directed();
		blk_word_t e;
		bit seq_now;
		seq_now = 0;
		foreach (vecs[i]) begin
			if (vecs[i].seq_key != seq_now || vecs[i].ksz != ksz_r || vecs[i].dir != dir_r) begin
				park_input();
				wait_idle();
				if (vecs[i].seq_key != seq_now) begin
					reg_write(acbc_pkg::REG_KEY0, 64'h0001020304050607);
					reg_write(acbc_pkg::REG_KEY1, 64'h08090a0b0c0d0e0f);
					reg_write(acbc_pkg::REG_KEY2, 64'h1011121314151617);
					reg_write(acbc_pkg::REG_KEY3, 64'h18191a1b1c1d1e1f);
					seq_now = 1;
				end
				reg_write(acbc_pkg::REG_KEY_SIZE, {62'd0, vecs[i].ksz});
				reg_write(acbc_pkg::REG_DIR, {63'd0, vecs[i].dir});
			end
			send_word(vecs[i].hi, vecs[i].lo, vecs[i].last);
			// typed-in vector overrides the predictor's entry for this word
			if (vecs[i].known) begin
				e.hi = vecs[i].res[127:64];
				e.lo = vecs[i].res[63:0];
				e.last = vecs[i].last;
				cbc_expect_q[cbc_expect_q.size()-1] = e;
			end
		end
		park_input();
	endtask

	// long receiver hold-off, counted in its own process
	task automatic rx_long_hold();
		rx_hold = 1'b1;
		repeat (400) @(negedge clk);
		rx_hold = 1'b0;
	endtask

	// ---------------------------------------------------------------
	// main sequence
	// ---------------------------------------------------------------
	initial begin
		int sent;
		logic [1:0] ksz_pick;
		for (int i = 0; i < 256; i++) begin
			fwd_sb[i] = acbc_pkg::SBOX[i];
			inv_sb[acbc_pkg::SBOX[i]] = i[7:0];
		end
		key_r = '{default: '0};
		ksz_r = acbc_pkg::KS_128;
		dir_r = 1'b0;
		iv_hi_r = '0;
		iv_lo_r = '0;
		chain_r = '0;
		build_schedule();

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// nonzero IV before the vectors would break them, so vectors run first
		run_directed();
		wait_idle();
		reg_write(acbc_pkg::REG_IV_HIGH, ONES);
		reg_write(acbc_pkg::REG_IV_LOW, ONES);
		send_word(ONES, ONES, 1'b1);
		park_input();

		sent = 0;
		for (int ph = 0; sent < RUN_WORDS; ph++) begin
			wait_idle();
			// each phase rewrites a random subset; first phase writes all
			if (ph == 0 || $urandom_range(1)) reg_write(acbc_pkg::REG_KEY0, rand64());
			if (ph == 0 || $urandom_range(1)) reg_write(acbc_pkg::REG_KEY1, rand64());
			if (ph == 0 || $urandom_range(1)) reg_write(acbc_pkg::REG_KEY2, rand64());
			if (ph == 0 || $urandom_range(1)) reg_write(acbc_pkg::REG_KEY3, rand64());
			if (ph == 0 || $urandom_range(1)) begin
				ksz_pick = $urandom_range(3);
				reg_write(acbc_pkg::REG_KEY_SIZE, {62'd0, ksz_pick});
			end
			if (ph == 0 || $urandom_range(1))
				reg_write(acbc_pkg::REG_DIR, {63'd0, 1'($urandom_range(1))});
			if (ph == 0 || $urandom_range(3) != 0) reg_write(acbc_pkg::REG_IV_HIGH, rand64());
			if (ph == 0 || $urandom_range(3) != 0) reg_write(acbc_pkg::REG_IV_LOW, rand64());

			tx_gaps = !(ph == 4);
			rx_gaps = !(ph == 4);
			if (ph == 2)
				fork
					rx_long_hold();
				join_none

			for (int j = 0; j < 120; j++) begin
				// a phase may end mid-message so the chain spans a config change
				send_word(rand64(), rand64(),
					(j == 119 && $urandom_range(1)) ? 1'b0 : ($urandom_range(9) < 2));
				sent++;
				if (ph == 6 && j == 60) begin
					// sender pause until everything has drained
					park_input();
					while (cbc_expect_q.size() != 0)
						@(posedge clk);
					@(negedge clk);
				end
			end
			park_input();
			tx_gaps = 1'b1;
			rx_gaps = 1'b1;
		end

		while (cbc_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (n_fail == 0)
			$display("aes_cbc_cipher test passed");
		else
			$display("aes_cbc_cipher test failed");
		$finish;
	end

endmodule

[filelist.f]
sv/acbc_pkg.sv
sv/acbc_ctrl.sv
sv/acbc_ksched.sv
sv/acbc_dp.sv
sv/aes_cbc_cipher.sv
sim/tb.sv
